// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros for the split table RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define STM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check on every clock edge, reset included.
`define STM_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/stm_pkg.sv
// ----------------------------------------------------------------------------
// stm_pkg
// Types and constants for the split table match block.
// ----------------------------------------------------------------------------
package stm_pkg;

    // parameter defaults
    localparam int MAX_TAXA_DEF    = 64;
    localparam int TABLE_DEPTH_DEF = 64;

    // field widths
    localparam int SPLIT_W = 64;
    localparam int SLOT_W  = 6;
    localparam int CFG_W   = 7;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    // register map (index = paddr[2])
    localparam logic REG_TAXA_USED      = 1'b0;
    localparam logic REG_ACTIVE_ENTRIES = 1'b1;

    localparam logic [CFG_W-1:0] TAXA_USED_RST      = 7'd64;
    localparam logic [CFG_W-1:0] ACTIVE_ENTRIES_RST = 7'd0;

    // request modes
    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } t_state;

endpackage

// File: rtl/core/stm_ram.sv
// ----------------------------------------------------------------------------
// stm_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module stm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/split_table_match.sv
// ----------------------------------------------------------------------------
// split_table_match
// Split (bipartition) table with equal-or-complement lookup.
// ----------------------------------------------------------------------------
// A write request stores its split at slot entry_index; its result
// (found = 0, match_index = 0) goes to the output register, or is parked in
// S_HOLD while that register is still occupied. A lookup request scans
// slots 0 .. count-1, count being min(active_entries, TABLE_DEPTH), one slot
// per cycle through the single read port of the table RAM, and stops at the
// first match. The RAM read data is registered ahead of each compare. A
// lookup with count zero finishes without a scan and with no match. A new
// request is accepted as soon as the previous one has handed its result to
// the output register, even while that result still waits for i_ready. The
// table has no reset and no clearing pass: slots must be written before any
// lookup reaches them.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module split_table_match #(
    parameter int MAX_TAXA    = stm_pkg::MAX_TAXA_DEF,
    parameter int TABLE_DEPTH = stm_pkg::TABLE_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request channel
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_mode,
    input  logic [stm_pkg::SLOT_W-1:0]   i_entry_index,
    input  logic [stm_pkg::SPLIT_W-1:0]  i_split_bits,
    // result channel
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_found,
    output logic [stm_pkg::SLOT_W-1:0]   o_match_index,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [stm_pkg::PADDR_W-1:0]  paddr,
    input  logic [stm_pkg::PDATA_W-1:0]  pwdata,
    output logic [stm_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);

    import stm_pkg::*;

    // table address width, and count width able to hold TABLE_DEPTH itself
    localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW   = $clog2(TABLE_DEPTH + 1);
    localparam int CMPW = (IW > CFG_W) ? IW : CFG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_taxa_used;
    logic [CFG_W-1:0] r_active_entries;
    logic             cfg_we;
    logic             cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taxa_used      <= TAXA_USED_RST;
            r_active_entries <= ACTIVE_ENTRIES_RST;
        end else if (cfg_we) begin
            case (cfg_idx)
                REG_TAXA_USED:      r_taxa_used      <= pwdata[CFG_W-1:0];
                REG_ACTIVE_ENTRIES: r_active_entries <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TAXA_USED:      prdata = {{(PDATA_W-CFG_W){1'b0}}, r_taxa_used};
            REG_ACTIVE_ENTRIES: prdata = {{(PDATA_W-CFG_W){1'b0}}, r_active_entries};
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Lookup setup: compare mask and scan length, latched on acceptance
    // ------------------------------------------------------------------
    logic [CFG_W-1:0]   taxa_eff;
    logic [SPLIT_W-1:0] mask_new;
    logic [CMPW-1:0]    active_ext;
    logic [IW-1:0]      count_new;

    always_comb begin
        // taxa above MAX_TAXA saturate
        taxa_eff = (r_taxa_used > CFG_W'(MAX_TAXA)) ? CFG_W'(MAX_TAXA) : r_taxa_used;
        for (int b = 0; b < SPLIT_W; b++) begin
            mask_new[b] = (CFG_W'(b) < taxa_eff);
        end
        active_ext = CMPW'(r_active_entries);
        if (active_ext >= CMPW'(TABLE_DEPTH)) begin
            count_new = IW'(TABLE_DEPTH);
        end else begin
            count_new = IW'(active_ext);
        end
    end

    // ------------------------------------------------------------------
    // Table RAM
    // ------------------------------------------------------------------
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [SPLIT_W-1:0] ram_rdata;
    logic [AW+SLOT_W-1:0] waddr_ext;

    logic               accept;
    logic               slot_ok;

    assign accept    = i_valid & o_ready;
    assign slot_ok   = ({{(32-SLOT_W){1'b0}}, i_entry_index} < 32'(TABLE_DEPTH));
    assign waddr_ext = {{AW{1'b0}}, i_entry_index};
    assign ram_waddr = waddr_ext[AW-1:0];
    // writes only happen while idle and reads only while scanning, so a
    // read never overlaps a write to the same slot
    assign ram_we    = accept & (i_mode == MODE_WRITE) & slot_ok;

    stm_ram #(
        .WIDTH (SPLIT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_split_bits),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Scan sequencer
    // ------------------------------------------------------------------
    t_state             r_state, n_state;
    logic [SPLIT_W-1:0] r_query, n_query;
    logic [SPLIT_W-1:0] r_mask, n_mask;
    logic [IW-1:0]      r_count, n_count;
    logic [IW-1:0]      r_rd_ptr, n_rd_ptr;   // next slot to read
    logic               r_chk_valid, n_chk_valid; // RAM data valid this cycle
    logic [IW-1:0]      r_chk_idx, n_chk_idx; // slot of the RAM data
    logic               r_res_found, n_res_found; // result parked in S_HOLD
    logic [SLOT_W-1:0]  r_res_idx, n_res_idx;

    logic               r_out_valid, n_out_valid;
    logic               r_out_found, n_out_found;
    logic [SLOT_W-1:0]  r_out_idx, n_out_idx;

    logic [SPLIT_W-1:0] x_bits;
    logic [SPLIT_W-1:0] diff;
    logic               hit;
    logic [IW+SLOT_W-1:0] chk_idx_ext;

    logic               finish;
    logic               fin_found;
    logic [SLOT_W-1:0]  fin_idx;
    logic               out_free;

    // equal over the mask, or complement when bit 0 differs
    assign x_bits      = r_query ^ ram_rdata;
    assign diff        = x_bits & r_mask;
    assign hit         = (diff == '0) | (x_bits[0] & (diff == r_mask));
    assign chk_idx_ext = {{SLOT_W{1'b0}}, r_chk_idx};
    assign out_free    = ~r_out_valid | i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_query     <= n_query;
        r_mask      <= n_mask;
        r_count     <= n_count;
        r_rd_ptr    <= n_rd_ptr;
        r_chk_idx   <= n_chk_idx;
        r_res_found <= n_res_found;
        r_res_idx   <= n_res_idx;
        r_out_found <= n_out_found;
        r_out_idx   <= n_out_idx;
    end

    always_comb begin
        n_state     = r_state;
        n_query     = r_query;
        n_mask      = r_mask;
        n_count     = r_count;
        n_rd_ptr    = r_rd_ptr;
        n_chk_valid = 1'b0;
        n_chk_idx   = r_chk_idx;
        n_res_found = r_res_found;
        n_res_idx   = r_res_idx;
        ram_re      = 1'b0;
        ram_raddr   = r_rd_ptr[AW-1:0];
        finish      = 1'b0;
        fin_found   = 1'b0;
        fin_idx     = '0;
        o_ready     = 1'b0;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (accept) begin
                    if (i_mode == MODE_WRITE || count_new == '0) begin
                        finish = 1'b1;
                    end else begin
                        n_query  = i_split_bits;
                        n_mask   = mask_new;
                        n_count  = count_new;
                        n_rd_ptr = '0;
                        n_state  = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_valid && hit) begin
                    finish    = 1'b1;
                    fin_found = 1'b1;
                    fin_idx   = chk_idx_ext[SLOT_W-1:0];
                end else if (!r_chk_valid && r_rd_ptr == r_count) begin
                    // every slot checked, no match
                    finish = 1'b1;
                end else if (r_rd_ptr != r_count) begin
                    ram_re      = 1'b1;
                    n_rd_ptr    = r_rd_ptr + IW'(1);
                    n_chk_valid = 1'b1;
                    n_chk_idx   = r_rd_ptr;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // hand the result on, or park it when the output register is still occupied
        if (finish) begin
            n_res_found = fin_found;
            n_res_idx   = fin_idx;
            n_state     = out_free ? S_IDLE : S_HOLD;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_comb begin
        n_out_valid = r_out_valid & ~i_ready;
        n_out_found = r_out_found;
        n_out_idx   = r_out_idx;
        if (finish && out_free) begin
            n_out_valid = 1'b1;
            n_out_found = fin_found;
            n_out_idx   = fin_idx;
        end else if (r_state == S_HOLD && out_free) begin
            n_out_valid = 1'b1;
            n_out_found = r_res_found;
            n_out_idx   = r_res_idx;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_out_found;
    assign o_match_index = r_out_idx;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `STM_ASSERT(a_chk_in_scan, i_clk, i_rst_n, r_chk_valid |-> (r_state == S_SCAN), "RAM data pending outside scan")
    `STM_ASSERT(a_ptr_bound, i_clk, i_rst_n, (r_state == S_SCAN) |-> (r_rd_ptr <= r_count), "read pointer past scan length")
    `STM_ASSERT(a_no_wr_scan, i_clk, i_rst_n, ram_we |-> (r_state == S_IDLE && !r_chk_valid), "table write during scan")
    `STM_ASSERT(a_hold_full, i_clk, i_rst_n, (r_state == S_HOLD) |-> r_out_valid, "result parked with output register empty")

endmodule
